>>> hw/rtl/text_cell_pixel_renderer_assert.svh
// Assertion macros shared by the checker of the text cell pixel renderer.
`ifndef TEXT_CELL_PIXEL_RENDERER_ASSERT_SVH
`define TEXT_CELL_PIXEL_RENDERER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tcr assertion failed");

// Next-cycle implication, checked outside reset.
`define TCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tcr assertion failed");

`endif

>>> hw/rtl/tcr_pkg.sv
// Types and constants shared by the text cell pixel renderer modules.
package tcr_pkg;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam int FONT_AW        = 12;
  localparam int FONT_DEPTH     = 4096;
  localparam int PAL_AW         = 4;
  localparam int PAL_DEPTH      = 16;
  localparam int PAL_LOAD_LIMIT = 2 * PAL_DEPTH;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [2:0] LAST_PIXEL = 3'd7;

  typedef enum logic [1:0] {
    OP_RENDER = 2'd0,
    OP_FONT   = 2'd1,
    OP_PAL    = 2'd2
  } op_t;

  // register index as decoded from paddr[2]
  localparam logic CFG_IDX_CURSOR_COLUMN = 1'b0;
  localparam logic CFG_IDX_CURSOR_ROW    = 1'b1;

  // input tdata layout, lowest bits last
  typedef struct packed {
    logic [2:0]  pad;
    logic [7:0]  load_data;
    logic [11:0] load_address;
    logic        blink_phase;
    logic [7:0]  attribute;
    logic [7:0]  char_code;
    logic [3:0]  glyph_row;
    logic [4:0]  cell_row;
    logic [6:0]  cell_column;
  } in_item_t;

  // output tdata layout, lowest bits last
  typedef struct packed {
    logic       pad;
    logic [3:0] blue;
    logic [3:0] green;
    logic [3:0] red;
    logic [8:0] pixel_y;
    logic [9:0] pixel_x;
  } out_pix_t;

  // one queued request between front and back
  typedef struct packed {
    op_t                op;
    logic [FONT_AW-1:0] addr;
    logic [7:0]         data;
    logic [6:0]         col;
    logic [8:0]         py;
    logic [7:0]         attr;
    logic               invert;
  } qent_t;

endpackage

>>> hw/rtl/tcr_fifo.sv
// Short request queue between the front and the back of the renderer.
module tcr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcr_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output tcr_pkg::qent_t head
);
  import tcr_pkg::*;

  qent_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/tcr_front.sv
// Front end: request intake, classification, cursor registers and APB port.
module tcr_front #(
  parameter int GLYPH_LINES       = 16,
  parameter int CURSOR_FIRST_LINE = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tcr_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [tcr_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tcr_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [tcr_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [tcr_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                cfg_pready,
  output logic                                q_push,
  output tcr_pkg::qent_t                      q_ent,
  input  logic                                q_full
);
  import tcr_pkg::*;

  logic [7:0] cursor_column_r, cursor_row_r;
  in_item_t   item;
  logic       cfg_wr, keep, at_cursor;
  logic [31:0] faddr_full, py_full;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_column_r <= '0;
      cursor_row_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CFG_IDX_CURSOR_COLUMN: cursor_column_r <= cfg_pwdata[7:0];
        CFG_IDX_CURSOR_ROW:    cursor_row_r    <= cfg_pwdata[7:0];
        default:               cursor_column_r <= cursor_column_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      CFG_IDX_CURSOR_COLUMN: cfg_prdata = {(CFG_DW-8)'(0), cursor_column_r};
      CFG_IDX_CURSOR_ROW:    cfg_prdata = {(CFG_DW-8)'(0), cursor_row_r};
      default:               cfg_prdata = '0;
    endcase
  end

  assign item      = in_item_t'(in_tdata);
  assign in_tready = !q_full;

  // font row address and screen line; both wrap to their field widths
  assign faddr_full = 32'(item.char_code) * 32'(GLYPH_LINES) + 32'(item.glyph_row);
  assign py_full    = 32'(item.cell_row) * 32'(GLYPH_LINES) + 32'(item.glyph_row);
  assign at_cursor  = (8'(item.cell_column) == cursor_column_r) &&
                      (8'(item.cell_row) == cursor_row_r) &&
                      (32'(item.glyph_row) >= 32'(CURSOR_FIRST_LINE));

  // drop unused op code and out-of-range palette writes here
  always_comb begin
    unique case (in_tuser)
      OP_RENDER: keep = 1'b1;
      OP_FONT:   keep = 1'b1;
      OP_PAL:    keep = (32'(item.load_address) < 32'(PAL_LOAD_LIMIT));
      default:   keep = 1'b0;
    endcase
  end

  assign q_push = in_tvalid && in_tready && keep;

  always_comb begin
    q_ent.op     = op_t'(in_tuser);
    q_ent.addr   = (in_tuser == OP_RENDER) ? faddr_full[FONT_AW-1:0] : item.load_address;
    q_ent.data   = item.load_data;
    q_ent.col    = item.cell_column;
    q_ent.py     = py_full[8:0];
    q_ent.attr   = item.attribute;
    q_ent.invert = item.blink_phase && at_cursor;
  end

endmodule

>>> hw/rtl/tcr_back.sv
// Back end: font and palette stores, pixel sequencer and output register.
module tcr_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  tcr_pkg::qent_t                   q_head,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tcr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import tcr_pkg::*;

  logic [7:0]        font_mem [FONT_DEPTH];
  logic [7:0]        pal_bg_r [PAL_DEPTH];
  logic [3:0]        pal_red_r [PAL_DEPTH];

  logic [7:0]        font_rd_r;
  logic              busy_r, busy_nxt;
  logic [2:0]        cnt_r;
  logic [6:0]        col_r;
  logic [8:0]        py_r;
  logic [7:0]        attr_r;
  logic              inv_r;
  logic              out_valid_r;
  out_pix_t          pix_r, pix_nxt;
  logic              last_r;

  logic              adv, fg;
  logic [PAL_AW-1:0] idx;

  assign adv   = busy_r && (!out_valid_r || out_tready);
  assign q_pop = q_valid && (!busy_r || (adv && cnt_r == LAST_PIXEL));

  // font store: write port and registered read port
  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == OP_FONT) font_mem[q_head.addr] <= q_head.data;
    if (q_pop && q_head.op == OP_RENDER) font_rd_r <= font_mem[q_head.addr];
  end

  // palette: even byte green/blue, odd byte red
  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == OP_PAL) begin
      if (q_head.addr[0]) pal_red_r[q_head.addr[PAL_AW:1]] <= q_head.data[3:0];
      else                pal_bg_r[q_head.addr[PAL_AW:1]]  <= q_head.data;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (adv && cnt_r == LAST_PIXEL) busy_nxt = 1'b0;
    if (q_pop && q_head.op == OP_RENDER) busy_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (q_pop && q_head.op == OP_RENDER) cnt_r <= '0;
      else if (adv)                        cnt_r <= cnt_r + 1'b1;
      if (adv)             out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == OP_RENDER) begin
      col_r  <= q_head.col;
      py_r   <= q_head.py;
      attr_r <= q_head.attr;
      inv_r  <= q_head.invert;
    end
    if (adv) begin
      pix_r  <= pix_nxt;
      last_r <= (cnt_r == LAST_PIXEL);
    end
  end

  // MSB of the font byte goes out first
  assign fg  = font_rd_r[LAST_PIXEL - cnt_r] ^ inv_r;
  assign idx = fg ? attr_r[3:0] : attr_r[7:4];

  always_comb begin
    pix_nxt.pad     = 1'b0;
    pix_nxt.pixel_x = {col_r, cnt_r};
    pix_nxt.pixel_y = py_r;
    pix_nxt.red     = pal_red_r[idx];
    pix_nxt.green   = pal_bg_r[idx][7:4];
    pix_nxt.blue    = pal_bg_r[idx][3:0];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(pix_r);
  assign out_tlast  = last_r;

endmodule

>>> hw/rtl/text_cell_pixel_renderer.sv
// Text-mode 8x16 character generator: font/palette loads and glyph-row rendering.
//
// Input stream (in_*): one request per tvalid/tready handshake. in_tuser is the op:
// render a glyph row, write a font byte, or write a palette byte. Loads produce no
// output; a render produces eight pixels on the output stream (out_*), leftmost
// pixel first, with out_tlast set on the eighth.
// Throughput: a render yields one pixel per cycle from the pixel sequencer unless
// out_tready holds it (set by the single output register); a load does not occupy it.
// The 4-entry request queue lets the input keep accepting while pixels drain.
// Path: on an idle block the first pixel of an accepted render passes the queue entry,
// the font read register (loaded as the queue pops) and then the output register.
// Stall: when out_tready is low the output register holds its pixel, the sequencer
// stops, and in_tready drops once the queue is full. Reset (rst_n low, synchronous)
// empties the queue and the output register and clears the cursor registers; font
// and palette contents stay undefined until loaded. Cursor registers are written
// over the APB port (cfg_*); the user must do so only while idle (not enforced).
module text_cell_pixel_renderer #(
  parameter int GLYPH_LINES       = 16,
  parameter int CURSOR_FIRST_LINE = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [6:0] cell_column, [11:7] cell_row, [15:12] glyph_row, [23:16] char_code,
  // [31:24] attribute, [32] blink_phase, [44:33] load_address, [52:45] load_data
  input  logic [tcr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] op
  input  logic [tcr_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [9:0] pixel_x, [18:10] pixel_y, [22:19] red, [26:23] green, [30:27] blue
  output logic [tcr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tcr_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [tcr_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [tcr_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import tcr_pkg::*;

  logic  q_push, q_full, q_pop, q_valid;
  qent_t q_ent, q_head;

  // intake: decodes the request, precomputes font address, screen line and
  // cursor inversion, and filters requests that do nothing
  tcr_front #(
    .GLYPH_LINES       (GLYPH_LINES),
    .CURSOR_FIRST_LINE (CURSOR_FIRST_LINE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .q_push      (q_push),
    .q_ent       (q_ent),
    .q_full      (q_full)
  );

  // loads travel through the queue too, so stores change in request order
  tcr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_ent),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // stores and pixel sequencer; the next request is popped on the last pixel or while idle
  tcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> hw/rtl/tcr_checker.sv
// Port-level checker for the text cell pixel renderer, bound to the top level.
`include "text_cell_pixel_renderer_assert.svh"

module tcr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tcr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tlast
);
  import tcr_pkg::*;

  // stalled pixel holds
  `TCR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // tlast marks exactly the pixel at bit position seven
  `TCR_ASSERT_NOW(a_last_pos, clk, rst_n, out_tvalid,
    out_tlast == (out_tdata[2:0] == LAST_PIXEL))

  // pixels of a glyph row come back to back once the receiver takes them
  `TCR_ASSERT_NEXT(a_row_burst, clk, rst_n, out_tvalid && out_tready && !out_tlast,
    out_tvalid)

endmodule

bind text_cell_pixel_renderer tcr_checker u_tcr_checker (.*);

>>> tb/sv/text_cell_pixel_renderer_tb.sv
// Self-checking testbench for the text cell pixel renderer.
module text_cell_pixel_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcr_pkg::*;

  // Geometry matching the DUT defaults
  localparam int GLYPH_LINES       = 16;
  localparam int CURSOR_FIRST_LINE = 14;
  // Op code the block must swallow silently; the package enum has no name for it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Quiet cycles tolerated before the run is declared hung. The longest legal
  // silence is the receiver hold-off below plus a config sequence and a drain.
  localparam int QUIET_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 300;
  // Idle cycles allowed after the last pixel: the pipe plus a queue of loads
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [1:0] op;
    in_item_t   item;
  } cell_req_t;

  typedef struct {
    out_pix_t px;
    logic     last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [6:0] cell_column, [11:7] cell_row, [15:12] glyph_row, [23:16] char_code,
  // [31:24] attribute, [32] blink_phase, [44:33] load_address, [52:45] load_data
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // [1:0] op
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [9:0] pixel_x, [18:10] pixel_y, [22:19] red, [26:23] green, [30:27] blue
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  text_cell_pixel_renderer dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: font image, split palette, cursor registers
  // ---------------------------------------------------------------------------
  logic [7:0] font_img [FONT_DEPTH];
  logic [7:0] pal_gb   [PAL_DEPTH];
  logic [3:0] pal_r    [PAL_DEPTH];
  logic [7:0] cursor_col = 8'd0;
  logic [7:0] cursor_row = 8'd0;

  cell_req_t req_fifo   [$];  // requests waiting to be driven
  pixel_t    pixels_due [$];  // pixels owed by the block, oldest first
  int        errors = 0;

  // Generator bookkeeping: never render from a font byte that was not loaded
  bit font_seen [FONT_DEPTH];
  int font_used [$];

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int tx_gap = 0;
  int rx_wait = 0;
  int rx_hold = 0;        // long hold-off, armed by the sequencer, spent by the sink
  int quiet_cycles = 0;

  // Random wait per request or pixel; calm stretches run back to back
  function automatic int draw_gap(input bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Update the shadow for one accepted request and queue the pixels it owes.
  task automatic emulate_request(input cell_req_t r);
    logic [11:0] faddr;
    logic [7:0]  bits;
    logic        invert;
    logic        at_cursor;
    logic [3:0]  idx;
    logic [8:0]  py;
    pixel_t      p;
    case (r.op)
      OP_FONT: font_img[r.item.load_address] = r.item.load_data;
      OP_PAL: begin
        // out-of-range palette addresses are dropped
        if (r.item.load_address < PAL_LOAD_LIMIT) begin
          if (r.item.load_address[0]) pal_r[r.item.load_address[4:1]] = r.item.load_data[3:0];
          else pal_gb[r.item.load_address[4:1]] = r.item.load_data;
        end
      end
      OP_RENDER: begin
        faddr = 12'(r.item.char_code * GLYPH_LINES + r.item.glyph_row);
        bits = font_img[faddr];
        at_cursor = ({1'b0, r.item.cell_column} == cursor_col) &&
                    ({3'b0, r.item.cell_row} == cursor_row) &&
                    (r.item.glyph_row >= CURSOR_FIRST_LINE);
        invert = r.item.blink_phase & at_cursor;
        py = 9'(r.item.cell_row * GLYPH_LINES + r.item.glyph_row);
        for (int k = 0; k < 8; k++) begin
          idx = (bits[7-k] ^ invert) ? r.item.attribute[3:0] : r.item.attribute[7:4];
          p.px = '0;
          p.px.pixel_x = 10'(8 * r.item.cell_column + k);
          p.px.pixel_y = py;
          p.px.red     = pal_r[idx];
          p.px.green   = pal_gb[idx][7:4];
          p.px.blue    = pal_gb[idx][3:0];
          p.last       = (k == 7);
          pixels_due.push_back(p);
        end
      end
      default: ;  // unused op: nothing happens
    endcase
  endtask

  function automatic bit field_ok(input string name, input int unsigned want,
                                  input int unsigned got);
    if (want == got) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: presents req_fifo head, predicts at the accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    logic go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      go = in_tvalid;
      if (in_tvalid && in_tready) begin
        emulate_request(req_fifo.pop_front());
        if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
        tx_gap = draw_gap(tx_calm);
        go = 1'b0;
      end
      if (!go) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (req_fifo.size() > 0) begin
          go = 1'b1;
          in_tdata <= IN_TDATA_W'(req_fifo[0].item);
          in_tuser <= req_fifo[0].op;
        end
      end
      in_tvalid <= go;  // single update per edge
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel sink: random back-pressure, optional long hold-off, field checks
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    logic     rdy;
    out_pix_t got;
    pixel_t   want;
    bit       ok;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_pix_t'(out_tdata);
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, got tdata %h last %b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          ok = field_ok("pixel_x", want.px.pixel_x, got.pixel_x);
          ok &= field_ok("pixel_y", want.px.pixel_y, got.pixel_y);
          ok &= field_ok("red", want.px.red, got.red);
          ok &= field_ok("green", want.px.green, got.green);
          ok &= field_ok("blue", want.px.blue, got.blue);
          ok &= field_ok("last", want.last, out_tlast);
          if (!ok) errors++;
        end
        if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
        rx_wait = draw_gap(rx_calm);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rdy = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  // Hang detector: counts edges with no handshake on any port
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // All fields random, so fields an op ignores still toggle
  function automatic in_item_t noise_item();
    in_item_t it;
    it = in_item_t'(IN_TDATA_W'({$urandom(), $urandom()}));
    it.pad = '0;
    return it;
  endfunction

  task automatic push_req(input logic [1:0] op, input in_item_t it);
    cell_req_t r;
    r.op = op;
    r.item = it;
    req_fifo.push_back(r);
  endtask

  task automatic put_font(input logic [11:0] addr, input logic [7:0] data);
    in_item_t it;
    it = noise_item();
    it.load_address = addr;
    it.load_data = data;
    push_req(OP_FONT, it);
    if (!font_seen[addr]) begin
      font_seen[addr] = 1'b1;
      font_used.push_back(addr);
    end
  endtask

  task automatic put_palette(input logic [11:0] addr, input logic [7:0] data);
    in_item_t it;
    it = noise_item();
    it.load_address = addr;
    it.load_data = data;
    push_req(OP_PAL, it);
  endtask

  task automatic put_render(input logic [7:0] code, input logic [3:0] line,
                            input logic [6:0] col, input logic [4:0] row,
                            input logic [7:0] attr, input logic blink);
    in_item_t it;
    it = noise_item();
    it.char_code = code;
    it.glyph_row = line;
    it.cell_column = col;
    it.cell_row = row;
    it.attribute = attr;
    it.blink_phase = blink;
    push_req(OP_RENDER, it);
  endtask

  // Render a loaded font byte; when aiming, land on the cursor cell
  task automatic render_loaded(input logic [11:0] addr, input bit aim);
    logic [6:0] col;
    logic [4:0] row;
    col = aim ? cursor_col[6:0] : 7'($urandom());
    row = aim ? cursor_row[4:0] : 5'($urandom());
    put_render(addr[11:4], addr[3:0], col, row, 8'($urandom()),
               aim ? ($urandom_range(0, 3) != 0) : 1'($urandom()));
  endtask

  // Load-then-render pairs most often, plus re-renders, palette churn, stray font loads and junk
  task automatic random_phase(input int n);
    int          pick;
    bit          aim;
    logic [11:0] a;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      aim = (cursor_col < 128) && (cursor_row < 32) && ($urandom_range(0, 2) == 0);
      if (pick < 45) begin
        a = 12'($urandom());
        if (aim || $urandom_range(0, 3) == 0) a[3:0] = 4'($urandom_range(14, 15));
        put_font(a, 8'($urandom()));
        render_loaded(a, aim);
      end else if (pick < 75) begin
        render_loaded(12'(font_used[$urandom_range(0, font_used.size() - 1)]), aim);
      end else if (pick < 85) begin
        a = $urandom_range(0, 1) ? 12'($urandom_range(0, 31)) : 12'($urandom());
        put_palette(a, 8'($urandom()));
      end else if (pick < 93) begin
        put_font(12'($urandom()), 8'($urandom()));
      end else begin
        push_req(OP_UNUSED, noise_item());
      end
    end
  endtask

  // Wait until every request went in and every owed pixel came out, then
  // let the pipe settle (loads leave no trace at the output)
  task automatic drain();
    while (req_fifo.size() > 0 || pixels_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write or read-back of one cursor register
  task automatic cfg_access(input logic idx, input logic [7:0] val, input logic wr);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'($urandom()), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);  // access edge: write lands, read data is valid
    if (!wr && cfg_prdata[7:0] !== val) begin
      $display("%0t: cursor register %0d read back, expected %h, got %h",
               $time, idx, val, cfg_prdata[7:0]);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (wr) begin
      if (idx == CFG_IDX_CURSOR_COLUMN) cursor_col = val;
      else cursor_row = val;
    end
  endtask

  task automatic set_cursor(input logic [7:0] col, input logic [7:0] row);
    cfg_access(CFG_IDX_CURSOR_COLUMN, col, 1'b1);
    cfg_access(CFG_IDX_CURSOR_ROW, row, 1'b1);
    cfg_access(CFG_IDX_CURSOR_COLUMN, col, 1'b0);
    cfg_access(CFG_IDX_CURSOR_ROW, row, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every palette byte first so any attribute nibble reads loaded data
    for (int e = 0; e < 2 * PAL_DEPTH; e++) put_palette(12'(e), 8'($urandom()));

    // Directed: cursor still at its reset spot, cell (0,0)
    put_font(12'h000, 8'h00);
    put_render(8'h00, 4'd0, 7'd0, 5'd0, 8'h00, 1'b1);        // cursor cell, line too high
    put_font(12'hFFF, 8'hFF);
    put_render(8'hFF, 4'd15, 7'd127, 5'd31, 8'hFF, 1'b1);    // coordinate extremes
    put_font(12'h00E, 8'hA5);
    put_render(8'h00, 4'd14, 7'd0, 5'd0, 8'h3C, 1'b1);       // first underline line, blinking
    put_render(8'h00, 4'd14, 7'd0, 5'd0, 8'h3C, 1'b0);       // same, blink off
    put_font(12'h00D, 8'h81);
    put_render(8'h00, 4'd13, 7'd0, 5'd0, 8'hC3, 1'b1);       // line above the underline
    put_font(12'h00F, 8'h5A);
    put_render(8'h00, 4'd15, 7'd0, 5'd0, 8'h96, 1'b1);       // last line of the cursor
    put_render(8'h00, 4'd15, 7'd1, 5'd0, 8'h96, 1'b1);       // neighbor column
    put_render(8'h00, 4'd15, 7'd0, 5'd1, 8'h96, 1'b1);       // neighbor row
    put_palette(12'd32, 8'hFF);                              // just past the palette
    put_palette(12'hFFF, 8'h00);                             // far out of range
    push_req(OP_UNUSED, noise_item());
    put_palette(12'd10, 8'hFF);                              // entry 5, both halves
    put_palette(12'd11, 8'hFF);                              // upper nibble dropped
    put_render(8'hFF, 4'd15, 7'd64, 5'd16, 8'h55, 1'b0);
    drain();

    // Cursor parked off screen: no cell can match
    set_cursor(8'hFF, 8'hFF);
    random_phase(15);
    drain();

    // Cursor in the far corner; sink holds off while the source keeps pushing
    set_cursor(8'd127, 8'd31);
    rx_hold = RX_HOLD_CYCLES;
    for (int k = 0; k < 12; k++) begin
      put_font(12'($urandom()), 8'($urandom()));
      render_loaded(12'(font_used[font_used.size() - 1]), k[0]);
    end
    random_phase(15);
    drain();

    // Cursor on a visible cell; source stops mid-phase until the block is empty
    set_cursor(8'($urandom_range(0, 79)), 8'($urandom_range(0, 29)));
    random_phase(10);
    drain();
    random_phase(10);
    drain();

    // Back to the origin, written explicitly this time
    set_cursor(8'd0, 8'd0);
    random_phase(20);
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tcr_pkg.sv
hw/rtl/tcr_fifo.sv
hw/rtl/tcr_front.sv
hw/rtl/tcr_back.sv
hw/rtl/text_cell_pixel_renderer.sv
hw/rtl/tcr_checker.sv
tb/sv/text_cell_pixel_renderer_tb.sv
